### hdl/plpp_pkg.sv
package plpp_pkg;

  localparam int HEADER_BYTES     = 22;
  localparam int MAX_PACKET_BYTES = 65536;

  localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int EXP_W = 20;

  localparam logic [POS_W-1:0] POS_HEADER = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0] POS_MAX    = POS_W'(MAX_PACKET_BYTES);

  localparam logic [15:0] FLAG_OK_MASK = 16'h0001;

  localparam int PADDR_W = 3;

  typedef enum logic {
    REG_EXPECTED_MAGIC   = 1'b0,
    REG_EXPECTED_VERSION = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_POINT   = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_t;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_SHORT       = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_LENGTH  = 3'd4,
    ST_DUPLICATE   = 3'd5
  } packet_status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] point_index;
    logic [31:0] x_bits;
    logic [31:0] y_bits;
    logic [2:0]  packet_status;
    logic [31:0] packet_seq;
    logic [63:0] timestamp_ns;
    logic        ok_flag;
    logic [15:0] point_count;
  } out_item_t;

endpackage

### hdl/point_list_packet_parser.sv
// Point-list packet parser.
//
// The input channel (in_valid, in_ready, in_data) carries one datagram byte
// per transfer, with last_byte set on the final byte. The output channel
// (out_valid, out_ready, out_data) carries point results (result_kind 0)
// and one verdict per datagram (result_kind 1). The APB port programs the
// expected magic at address 0 and the expected version at address 4, and
// both read back; write them only while no datagram is in flight.
//
// Bytes can follow one another with no gap, so the sustained rate is one
// byte per cycle while in_ready is high. Each result is registered into the
// output register, or into the skid register while the output holds one. The
// header capture, point assembly and verdict checks sit between the parser
// state registers and the output register.
//
// When the receiver stalls, a held result stays on the output and one more
// result is kept in a skid register; in_ready drops only while that skid
// register is full. Reset clears the parser state, the sequence history,
// both configuration registers and all pending results.
module point_list_packet_parser
  import plpp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,

  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0]      exp_magic_r;
  logic [15:0]      exp_version_r;

  logic [POS_W-1:0] pos_r,        pos_nxt;
  logic [31:0]      magic_r,      magic_nxt;
  logic [15:0]      version_r,    version_nxt;
  logic [15:0]      flags_r,      flags_nxt;
  logic [31:0]      seq_r,        seq_nxt;
  logic [63:0]      time_r,       time_nxt;
  logic [15:0]      count_r,      count_nxt;
  logic [63:0]      asm_r,        asm_nxt;
  logic [15:0]      pcnt_r,       pcnt_nxt;
  logic             suppress_r,   suppress_nxt;
  logic [31:0]      last_seq_r,   last_seq_nxt;
  logic             has_seq_r,    has_seq_nxt;

  logic             out_vld_r;
  out_item_t        out_r;
  logic             skid_vld_r;
  out_item_t        skid_r;

  logic             in_fire;
  logic             pop;
  logic             res_vld;
  out_item_t        res;

  logic [POS_W-1:0] pos_off;
  logic [2:0]       lane;
  logic             have_point;
  logic             is_dup;
  logic [EXP_W-1:0] expect_len;
  logic [2:0]       status;
  logic             cfg_wr;

  assign in_ready = !skid_vld_r;
  assign in_fire  = in_valid && in_ready;
  assign pop      = out_vld_r && out_ready;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (reg_index_t'(paddr[2]))
      REG_EXPECTED_MAGIC:   prdata = exp_magic_r;
      REG_EXPECTED_VERSION: prdata = {16'd0, exp_version_r};
      default:              prdata = 32'd0;
    endcase
  end

  always_comb begin
    pos_nxt      = pos_r;
    magic_nxt    = magic_r;
    version_nxt  = version_r;
    flags_nxt    = flags_r;
    seq_nxt      = seq_r;
    time_nxt     = time_r;
    count_nxt    = count_r;
    asm_nxt      = asm_r;
    pcnt_nxt     = pcnt_r;
    suppress_nxt = suppress_r;
    last_seq_nxt = last_seq_r;
    has_seq_nxt  = has_seq_r;
    have_point   = 1'b0;
    pos_off      = pos_r - POS_HEADER;
    lane         = pos_off[2:0];
    is_dup       = 1'b0;
    expect_len   = '0;
    status       = ST_ACCEPTED;
    res          = '0;
    res_vld      = 1'b0;

    if (pos_r < POS_MAX) begin
      if (pos_r < POS_W'(4)) begin
        magic_nxt = {magic_r[23:0], in_data.data_byte};
      end else if (pos_r < POS_W'(6)) begin
        version_nxt = {version_r[7:0], in_data.data_byte};
      end else if (pos_r < POS_W'(8)) begin
        flags_nxt = {flags_r[7:0], in_data.data_byte};
      end else if (pos_r < POS_W'(12)) begin
        seq_nxt = {seq_r[23:0], in_data.data_byte};
      end else if (pos_r < POS_W'(20)) begin
        time_nxt = {time_r[55:0], in_data.data_byte};
      end else if (pos_r < POS_W'(22)) begin
        count_nxt = {count_r[7:0], in_data.data_byte};
      end

      is_dup = has_seq_r && (seq_nxt == last_seq_r);

      if (pos_r + POS_W'(1) == POS_HEADER) begin
        if (magic_nxt != exp_magic_r || version_nxt != exp_version_r || is_dup) begin
          suppress_nxt = 1'b1;
        end
      end

      if (pos_r >= POS_HEADER) begin
        asm_nxt[{lane, 3'b000} +: 8] = in_data.data_byte;
        if (lane == 3'd7) begin
          have_point = !suppress_r;
          pcnt_nxt   = pcnt_r + 16'd1;
        end
      end
      pos_nxt = pos_r + POS_W'(1);
    end

    is_dup = has_seq_r && (seq_nxt == last_seq_r);

    if (have_point) begin
      res.point_index = pcnt_r;
      res.x_bits      = asm_nxt[31:0];
      res.y_bits      = asm_nxt[63:32];
    end

    if (!in_data.last_byte) begin
      res.result_kind = KIND_POINT;
      res_vld         = have_point;
    end else begin
      res_vld         = 1'b1;
      res.result_kind = KIND_VERDICT;
      expect_len      = EXP_W'(HEADER_BYTES) + {1'b0, count_nxt, 3'b000};
      if (pos_nxt < POS_HEADER) begin
        status = ST_SHORT;
      end else begin
        if (magic_nxt != exp_magic_r) begin
          status = ST_BAD_MAGIC;
        end else if (version_nxt != exp_version_r) begin
          status = ST_BAD_VERSION;
        end else if (pos_nxt >= POS_MAX || EXP_W'(pos_nxt) != expect_len) begin
          status = ST_BAD_LENGTH;
        end else if (is_dup) begin
          status = ST_DUPLICATE;
        end else begin
          status = ST_ACCEPTED;
        end
        res.packet_seq   = seq_nxt;
        res.timestamp_ns = time_nxt;
        res.ok_flag      = |(flags_nxt & FLAG_OK_MASK);
        res.point_count  = count_nxt;
      end
      res.packet_status = status;
      if (status == ST_ACCEPTED) begin
        last_seq_nxt = seq_nxt;
        has_seq_nxt  = 1'b1;
      end
      pos_nxt      = '0;
      magic_nxt    = '0;
      version_nxt  = '0;
      flags_nxt    = '0;
      seq_nxt      = '0;
      time_nxt     = '0;
      count_nxt    = '0;
      asm_nxt      = '0;
      pcnt_nxt     = '0;
      suppress_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_magic_r   <= '0;
      exp_version_r <= '0;
    end else if (cfg_wr) begin
      case (reg_index_t'(paddr[2]))
        REG_EXPECTED_MAGIC:   exp_magic_r   <= pwdata;
        REG_EXPECTED_VERSION: exp_version_r <= pwdata[15:0];
        default:              ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      magic_r    <= '0;
      version_r  <= '0;
      flags_r    <= '0;
      seq_r      <= '0;
      time_r     <= '0;
      count_r    <= '0;
      asm_r      <= '0;
      pcnt_r     <= '0;
      suppress_r <= 1'b0;
      last_seq_r <= '0;
      has_seq_r  <= 1'b0;
    end else if (in_fire) begin
      pos_r      <= pos_nxt;
      magic_r    <= magic_nxt;
      version_r  <= version_nxt;
      flags_r    <= flags_nxt;
      seq_r      <= seq_nxt;
      time_r     <= time_nxt;
      count_r    <= count_nxt;
      asm_r      <= asm_nxt;
      pcnt_r     <= pcnt_nxt;
      suppress_r <= suppress_nxt;
      last_seq_r <= last_seq_nxt;
      has_seq_r  <= has_seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        out_r      <= skid_r;
        skid_vld_r <= 1'b0;
      end
    end else if (in_fire && res_vld) begin
      if (!out_vld_r || pop) begin
        out_r     <= res;
        out_vld_r <= 1'b1;
      end else begin
        skid_r     <= res;
        skid_vld_r <= 1'b1;
      end
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("Skid register holds a result while the output register is empty.");

  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("Byte position ran past the packet size limit.");

  a_point_meta_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.result_kind == KIND_POINT) |->
      (out_r.packet_status == ST_ACCEPTED && out_r.packet_seq == 32'd0 &&
       out_r.point_count == 16'd0 && !out_r.ok_flag))
    else $error("A point result carries verdict fields.");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.last_byte) |=> (pos_r == '0 && pcnt_r == 16'd0 && !suppress_r))
    else $error("Per-packet state was not cleared after the final byte.");

  a_seq_update_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !(in_data.last_byte && status == ST_ACCEPTED)) |=>
      $stable(last_seq_r) && $stable(has_seq_r))
    else $error("Sequence history changed without an accepted packet.");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
  import plpp_pkg::*;
();

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  point_list_packet_parser DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  logic [31:0] exp_magic_reg = '0;
  logic [15:0] exp_version_reg = '0;

  logic [POS_W-1:0] cur_pos = '0;
  logic [31:0] cur_magic = '0;
  logic [15:0] cur_version = '0;
  logic [15:0] cur_flags = '0;
  logic [31:0] cur_seq = '0;
  logic [63:0] cur_time = '0;
  logic [15:0] cur_count = '0;
  logic [63:0] cur_point = '0;
  logic [15:0] cur_point_idx = '0;
  logic cur_suppress = 1'b0;
  logic [31:0] accepted_seq = '0;
  logic seq_valid = 1'b0;

  out_item_t expected_results[$];
  logic [7:0] pkt[$];

  int error_count = 0;
  int points_seen = 0;
  int verdicts_seen = 0;
  int packets_sent = 0;
  int bytes_sent = 0;
  int hold_cycles = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(20_000_000);
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic is_duplicate();
    return seq_valid && (cur_seq == accepted_seq);
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    out_item_t r;
    logic have_point;
    logic [15:0] pidx;
    logic [63:0] pbits;
    logic [2:0] lane;
    packet_status_t status;
    have_point = 1'b0;
    pidx = '0;
    pbits = '0;
    r = '0;
    if (cur_pos < POS_MAX) begin
      if (cur_pos < 4) cur_magic = {cur_magic[23:0], b};
      else if (cur_pos < 6) cur_version = {cur_version[7:0], b};
      else if (cur_pos < 8) cur_flags = {cur_flags[7:0], b};
      else if (cur_pos < 12) cur_seq = {cur_seq[23:0], b};
      else if (cur_pos < 20) cur_time = {cur_time[55:0], b};
      else if (cur_pos < 22) cur_count = {cur_count[7:0], b};
      if (cur_pos + 1 == POS_HEADER) begin
        if (cur_magic != exp_magic_reg || cur_version != exp_version_reg || is_duplicate())
          cur_suppress = 1'b1;
      end
      if (cur_pos >= POS_HEADER) begin
        lane = 3'(cur_pos - POS_HEADER);
        cur_point[lane*8 +: 8] = b;
        if (lane == 3'd7) begin
          if (!cur_suppress) begin
            have_point = 1'b1;
            pidx = cur_point_idx;
            pbits = cur_point;
          end
          cur_point_idx = cur_point_idx + 16'd1;
        end
      end
      cur_pos = cur_pos + 1'b1;
    end
    if (have_point) begin
      r.point_index = pidx;
      r.x_bits = pbits[31:0];
      r.y_bits = pbits[63:32];
    end
    if (!last) begin
      if (have_point) begin
        r.result_kind = KIND_POINT;
        expected_results.push_back(r);
      end
    end else begin
      r.result_kind = KIND_VERDICT;
      if (cur_pos < POS_HEADER) begin
        status = ST_SHORT;
      end else begin
        if (cur_magic != exp_magic_reg) status = ST_BAD_MAGIC;
        else if (cur_version != exp_version_reg) status = ST_BAD_VERSION;
        else if (cur_pos >= POS_MAX || int'(cur_pos) != HEADER_BYTES + 8 * int'(cur_count))
          status = ST_BAD_LENGTH;
        else if (is_duplicate()) status = ST_DUPLICATE;
        else status = ST_ACCEPTED;
        r.packet_seq = cur_seq;
        r.timestamp_ns = cur_time;
        r.ok_flag = |(cur_flags & FLAG_OK_MASK);
        r.point_count = cur_count;
      end
      r.packet_status = status;
      expected_results.push_back(r);
      if (status == ST_ACCEPTED) begin
        accepted_seq = cur_seq;
        seq_valid = 1'b1;
      end
      cur_pos = '0;
      cur_magic = '0;
      cur_version = '0;
      cur_flags = '0;
      cur_seq = '0;
      cur_time = '0;
      cur_count = '0;
      cur_point = '0;
      cur_point_idx = '0;
      cur_suppress = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t ns: unexpected result, expected none, got %h", $time, out_data);
      end else begin
        want = expected_results.pop_front();
        check_field("result_kind", want.result_kind, out_data.result_kind);
        check_field("point_index", want.point_index, out_data.point_index);
        check_field("x_bits", want.x_bits, out_data.x_bits);
        check_field("y_bits", want.y_bits, out_data.y_bits);
        check_field("packet_status", want.packet_status, out_data.packet_status);
        check_field("packet_seq", want.packet_seq, out_data.packet_seq);
        check_field("timestamp_ns", want.timestamp_ns, out_data.timestamp_ns);
        check_field("ok_flag", want.ok_flag, out_data.ok_flag);
        check_field("point_count", want.point_count, out_data.point_count);
        if (want.result_kind == KIND_VERDICT) verdicts_seen++;
        else points_seen++;
      end
    end
  end

  initial begin : result_sink
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (rx_idle_en && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (tx_idle_en && $urandom_range(0, 99) < 25) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (!in_ready);
    parse_byte(b, last);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == REG_EXPECTED_VERSION) ? {16'h0, value[15:0]} : value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_EXPECTED_MAGIC) exp_magic_reg = value;
    else exp_version_reg = value[15:0];
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      error_count++;
      $display("%0t ns: register %s read back expected %h, got %h", $time, idx.name(), want,
               prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic start_packet(input logic [31:0] magic, input logic [15:0] version,
                              input logic [15:0] flags, input logic [31:0] seq,
                              input logic [63:0] stamp, input logic [15:0] count);
    pkt.delete();
    for (int i = 3; i >= 0; i--) pkt.push_back(magic[8*i +: 8]);
    for (int i = 1; i >= 0; i--) pkt.push_back(version[8*i +: 8]);
    for (int i = 1; i >= 0; i--) pkt.push_back(flags[8*i +: 8]);
    for (int i = 3; i >= 0; i--) pkt.push_back(seq[8*i +: 8]);
    for (int i = 7; i >= 0; i--) pkt.push_back(stamp[8*i +: 8]);
    for (int i = 1; i >= 0; i--) pkt.push_back(count[8*i +: 8]);
  endtask

  task automatic add_random_bytes(input int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic send_packet(input int pause_at);
    for (int i = 0; i < pkt.size(); i++) begin
      if (i == pause_at) wait_idle();
      send_byte(pkt[i], i == pkt.size() - 1);
    end
    packets_sent++;
  endtask

  task automatic test_short_packets();
    pkt.delete();
    pkt.push_back(8'hFF);
    send_packet(-1);
    pkt.delete();
    add_random_bytes(HEADER_BYTES - 1);
    send_packet(-1);
  endtask

  task automatic test_header_extremes();
    wait_idle();
    write_register(REG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
    write_register(REG_EXPECTED_VERSION, 32'h0000_FFFF);
    start_packet(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd2);
    repeat (8) pkt.push_back(8'hFF);
    repeat (8) pkt.push_back(8'h00);
    send_packet(-1);
    start_packet(32'hFFFF_FFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 64'h0, 16'd0);
    send_packet(-1);
  endtask

  task automatic test_header_checks();
    start_packet(32'h7FFF_FFFF, 16'h0000, 16'h0001, accepted_seq + 1, 64'h1, 16'd1);
    add_random_bytes(8);
    send_packet(-1);
    start_packet(exp_magic_reg, 16'hFFFE, 16'h0001, accepted_seq + 1, 64'h2, 16'd1);
    add_random_bytes(8);
    send_packet(-1);
    start_packet(exp_magic_reg, exp_version_reg, 16'h0001, accepted_seq + 1, 64'h3, 16'd3);
    add_random_bytes(16);
    send_packet(-1);
    start_packet(exp_magic_reg, exp_version_reg, 16'h0000, accepted_seq + 1, 64'h4, 16'd2);
    add_random_bytes(19);
    send_packet(-1);
    start_packet(exp_magic_reg, exp_version_reg, 16'h8001, accepted_seq, 64'h5, 16'd1);
    add_random_bytes(8);
    send_packet(-1);
  endtask

  task automatic test_fill_and_stall();
    tx_idle_en = 1'b0;
    hold_cycles = 200;
    start_packet(exp_magic_reg, exp_version_reg, 16'h0001, accepted_seq + 1, 64'h6, 16'd40);
    add_random_bytes(8 * 40);
    send_packet(-1);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_pause_mid_packet();
    start_packet(exp_magic_reg, exp_version_reg, 16'h0001, accepted_seq + 1, 64'h7, 16'd3);
    add_random_bytes(24);
    send_packet(HEADER_BYTES + 12);
  endtask

  task automatic send_random_packet();
    int sel;
    int npts;
    logic [31:0] magic;
    logic [31:0] seq;
    logic [15:0] version;
    logic [15:0] count;
    sel = $urandom_range(0, 99);
    npts = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
    magic = exp_magic_reg;
    version = exp_version_reg;
    seq = ($urandom_range(0, 3) == 0 || !seq_valid) ? $urandom : accepted_seq + 1;
    count = 16'(npts);
    if (sel < 8) magic = magic ^ (32'h1 << $urandom_range(0, 31));
    else if (sel < 14) version = version ^ (16'h1 << $urandom_range(0, 15));
    else if (sel < 18) seq = accepted_seq;
    else if (sel < 24) count = 16'($urandom);
    start_packet(magic, version, 16'($urandom), seq, {$urandom, $urandom}, count);
    add_random_bytes(8 * npts);
    if (sel >= 24 && sel < 28) begin
      add_random_bytes($urandom_range(1, 7));
    end else if (sel >= 28 && sel < 32) begin
      pkt.delete();
      add_random_bytes($urandom_range(1, HEADER_BYTES - 1));
    end
    send_packet(($urandom_range(0, 19) == 0) ? $urandom_range(1, pkt.size() - 1) : -1);
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    for (int phase = 0; phase < 4; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_register(REG_EXPECTED_MAGIC, 32'hCAFE_F00D);
          write_register(REG_EXPECTED_VERSION, 32'h0000_0001);
        end
        1: begin
          write_register(REG_EXPECTED_MAGIC, $urandom);
          write_register(REG_EXPECTED_VERSION, {16'h0, 16'($urandom)});
        end
        2: begin
          write_register(REG_EXPECTED_MAGIC, 32'h0);
          write_register(REG_EXPECTED_VERSION, 32'h0);
        end
        default: begin
          write_register(REG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
          write_register(REG_EXPECTED_VERSION, 32'h0);
        end
      endcase
      tx_idle_en = (phase != 2);
      rx_idle_en = (phase != 2);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < 75) send_random_packet();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_short_packets();
    test_header_extremes();
    test_header_checks();
    test_fill_and_stall();
    test_pause_mid_packet();
    test_random_traffic();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d datagrams in %0d bytes: short, rejected, duplicate, paused and good.",
             packets_sent, bytes_sent);
    $display("Checked %0d point results and %0d verdicts.", points_seen, verdicts_seen);
    if (error_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
